FILE: sv/sse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Scanline sprite evaluator package
// Shared constants, command and result types and the scan state type.
// ----------------------------------------------------------------------------
package sse_pkg;

    localparam int SPRITE_COUNT  = 64;
    localparam int LINE_LIMIT    = 8;
    localparam int TABLE_BYTES   = 256;
    localparam int ROW_COUNT     = TABLE_BYTES / 4;
    localparam int ROW_W         = $clog2(ROW_COUNT);
    localparam int IDX_W         = $clog2(SPRITE_COUNT);
    localparam int CNT_W         = $clog2(SPRITE_COUNT + 1);
    localparam int NUM_W         = 6;
    localparam int VISIBLE_LINES = 240;
    localparam int SHORT_HEIGHT  = 8;
    localparam int TALL_HEIGHT   = 16;
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);
    localparam int IN_DATA_W     = 32;
    localparam int OUT_DATA_W    = 40;

    localparam logic [0:0] CFG_TALL_SPRITES = 1'b0;
    localparam logic [0:0] CFG_LIMIT_MODE   = 1'b1;

    localparam logic [1:0] LIMIT_ACCURATE  = 2'd0;
    localparam logic [1:0] LIMIT_LIMITED   = 2'd1;
    localparam logic [1:0] LIMIT_UNLIMITED = 2'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_EVAL,
        CMD_BLANK
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op          op;
        logic [ROW_W-1:0] row;
        logic [1:0]       lane;
        logic [7:0]       data;
        logic [7:0]       line;
    } t_cmd;

    typedef struct packed {
        logic             found;
        logic [NUM_W-1:0] num;
        logic [7:0]       y;
        logic [7:0]       tile;
        logic [7:0]       attr;
        logic [7:0]       x;
        logic             overflow;
        logic             set_status;
        logic             last;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage
`default_nettype wire

FILE: sv/scanline_sprite_evaluator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Scanline sprite evaluator
// Keeps a 64-entry sprite table and lists the sprites that cover a scanline.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser: kind; tdata: table_addr[7:0], table_data[15:8],
//                        line[24:16]
//   m_axis    out        tuser: found; tlast: last; tdata: sprite_number,
//                        sprite_y, sprite_tile, sprite_attr, sprite_x,
//                        overflow, set_status_overflow
//   cfg       in         index 0 tall_sprites, index 1 limit_mode
//
// A table write is done in the back end while it is idle. A scan holds the
// back end until every table row is read and its last word is sent: one row
// is read per cycle, unless an output stall holds it, through the table's single
// read port. A two-word command queue lets the input side run ahead of a scan.
// Reset is synchronous and needs no clearing pass: each table row carries a
// valid bit. Output stalls hold the scan when a new sprite is found while two
// found sprites are still waiting.
// ----------------------------------------------------------------------------
module scanline_sprite_evaluator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // table_addr [7:0], table_data [15:8], line [24:16], zero [31:25]
    input  wire logic [sse_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind [0]
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // sprite_number [5:0], sprite_y [13:6], sprite_tile [21:14],
    // sprite_attr [29:22], sprite_x [37:30], overflow [38],
    // set_status_overflow [39]
    output logic [sse_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // found [0]
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast,
    input  wire logic                            i_cfg_we,
    input  wire logic [0:0]                      i_cfg_index,
    input  wire logic [1:0]                      i_cfg_data
);

    logic             fifo_full;
    logic             fifo_empty;
    logic             push;
    logic             pop;
    sse_pkg::t_cmd    front_cmd;
    sse_pkg::t_cmd    head_cmd;
    sse_pkg::t_result result;

    sse_front u_front (
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_fifo_full (fifo_full),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    sse_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (fifo_full),
        .o_empty (fifo_empty),
        .o_head  (head_cmd)
    );

    sse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_empty     (fifo_empty),
        .i_head      (head_cmd),
        .o_pop       (pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tdata = {result.set_status, result.overflow, result.x, result.attr,
                           result.tile, result.y, result.num};
    assign m_axis_tuser = result.found;
    assign m_axis_tlast = result.last;

endmodule
`default_nettype wire

FILE: sv/sse_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Scanline sprite evaluator front end
// Accepts input words and classifies them into table writes, scans and
// blank lines for the command queue.
// ----------------------------------------------------------------------------
module sse_front (
    input  wire logic                           i_tvalid,
    output logic                                o_tready,
    input  wire logic [sse_pkg::IN_DATA_W-1:0]  i_tdata,
    input  wire logic                           i_tuser,
    input  wire logic                           i_fifo_full,
    output logic                                o_push,
    output sse_pkg::t_cmd                       o_cmd
);

    logic [8:0] line;

    assign line     = i_tdata[24:16];
    assign o_tready = !i_fifo_full;
    assign o_push   = i_tvalid && !i_fifo_full;

    always_comb begin
        o_cmd.row  = i_tdata[7:2];
        o_cmd.lane = i_tdata[1:0];
        o_cmd.data = i_tdata[15:8];
        o_cmd.line = line[7:0];
        if (i_tuser == sse_pkg::KIND_WRITE) begin
            o_cmd.op = sse_pkg::CMD_WRITE;
        end else if (line >= 9'(sse_pkg::VISIBLE_LINES)) begin
            o_cmd.op = sse_pkg::CMD_BLANK;
        end else begin
            o_cmd.op = sse_pkg::CMD_EVAL;
        end
    end

endmodule
`default_nettype wire

FILE: sv/sse_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Scanline sprite evaluator command queue
// Short queue of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
module sse_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sse_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output sse_pkg::t_cmd      o_head
);

    sse_pkg::t_cmd                  r_mem [sse_pkg::FIFO_DEPTH];
    logic [sse_pkg::FIFO_AW-1:0]    r_wr_ptr;
    logic [sse_pkg::FIFO_AW-1:0]    r_rd_ptr;
    logic [sse_pkg::FIFO_CW-1:0]    r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_count == sse_pkg::FIFO_CW'(sse_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == sse_pkg::FIFO_AW'(sse_pkg::FIFO_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == sse_pkg::FIFO_AW'(sse_pkg::FIFO_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/sse_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Scanline sprite evaluator back end
// Owns the sprite table, performs writes, scans one entry per cycle unless the
// output stalls; one found sprite is held back to put last on the right word.
// ----------------------------------------------------------------------------
module sse_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [0:0]    i_cfg_index,
    input  wire logic [1:0]    i_cfg_data,
    input  wire logic          i_empty,
    input  wire sse_pkg::t_cmd i_head,
    output logic               o_pop,
    output logic               o_tvalid,
    input  wire logic          i_tready,
    output sse_pkg::t_result   o_result
);

    sse_pkg::t_state            r_state, n_state;
    logic                       r_tall;
    logic [1:0]                 r_mode;
    logic [sse_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic                       r_issue_done, n_issue_done;
    logic                       r_chk_valid, n_chk_valid;
    logic [sse_pkg::IDX_W-1:0]  r_chk_idx, n_chk_idx;
    logic [7:0]                 r_line, n_line;
    logic [sse_pkg::CNT_W-1:0]  r_count, n_count;
    logic                       r_over, n_over;
    logic                       r_pend_valid, n_pend_valid;
    sse_pkg::t_result           r_pend, n_pend;
    logic                       r_out_valid, n_out_valid;
    sse_pkg::t_result           r_out, n_out;

    logic [31:0]                r_table [sse_pkg::ROW_COUNT];
    logic [sse_pkg::ROW_COUNT-1:0] r_row_valid;
    logic [31:0]                r_rd_data;
    logic                       r_rd_ok;

    logic                       mem_we;
    logic                       rd_en;
    logic [sse_pkg::ROW_W-1:0]  rd_row;
    logic [31:0]                entry;
    logic [8:0]                 top;
    logic [9:0]                 bottom;
    logic [4:0]                 height;
    logic [sse_pkg::CNT_W-1:0]  limit;
    logic                       hit;
    logic                       take;
    logic                       out_free;
    logic                       stall;
    sse_pkg::t_result           new_res;
    sse_pkg::t_result           empty_res;

    assign entry    = r_rd_ok ? r_rd_data : 32'h0;
    assign height   = r_tall ? 5'(sse_pkg::TALL_HEIGHT) : 5'(sse_pkg::SHORT_HEIGHT);
    assign top      = {1'b0, entry[7:0]} + 9'd1;
    assign bottom   = {1'b0, top} + 10'(height);
    assign hit      = ({1'b0, r_line} >= top) && ({2'b00, r_line} < bottom);
    assign limit    = (r_mode == sse_pkg::LIMIT_UNLIMITED) ?
                      sse_pkg::CNT_W'(sse_pkg::SPRITE_COUNT) :
                      sse_pkg::CNT_W'(sse_pkg::LINE_LIMIT);
    assign take     = r_chk_valid && hit && (r_count < limit);
    assign out_free = !r_out_valid || i_tready;
    assign stall    = take && r_pend_valid && !out_free;
    assign rd_row   = sse_pkg::ROW_W'(r_idx);
    assign o_tvalid = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        new_res            = '0;
        new_res.found      = 1'b1;
        new_res.num        = sse_pkg::NUM_W'(r_chk_idx);
        new_res.y          = entry[7:0];
        new_res.tile       = entry[15:8];
        new_res.attr       = entry[23:16];
        new_res.x          = entry[31:24];
        empty_res          = '0;
        empty_res.last     = 1'b1;
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_issue_done = r_issue_done;
        n_chk_valid  = r_chk_valid;
        n_chk_idx    = r_chk_idx;
        n_line       = r_line;
        n_count      = r_count;
        n_over       = r_over;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !i_tready;
        n_out        = r_out;
        o_pop        = 1'b0;
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        unique case (r_state)
            sse_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    unique case (i_head.op)
                        sse_pkg::CMD_WRITE: begin
                            mem_we = 1'b1;
                            o_pop  = 1'b1;
                        end
                        sse_pkg::CMD_EVAL: begin
                            o_pop        = 1'b1;
                            n_line       = i_head.line;
                            n_idx        = '0;
                            n_issue_done = 1'b0;
                            n_chk_valid  = 1'b0;
                            n_count      = '0;
                            n_over       = 1'b0;
                            n_pend_valid = 1'b0;
                            n_state      = sse_pkg::ST_SCAN;
                        end
                        sse_pkg::CMD_BLANK: begin
                            if (out_free) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_out       = empty_res;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            sse_pkg::ST_SCAN: begin
                if (!stall) begin
                    if (!r_issue_done) begin
                        rd_en       = 1'b1;
                        n_chk_valid = 1'b1;
                        n_chk_idx   = r_idx;
                        if (r_idx == sse_pkg::IDX_W'(sse_pkg::SPRITE_COUNT - 1)) begin
                            n_issue_done = 1'b1;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end else begin
                        n_chk_valid = 1'b0;
                        if (!r_chk_valid) begin
                            n_state = sse_pkg::ST_FINISH;
                        end
                    end
                    if (r_chk_valid && hit) begin
                        if (take) begin
                            n_count      = r_count + 1'b1;
                            n_pend       = new_res;
                            n_pend_valid = 1'b1;
                            if (r_pend_valid) begin
                                n_out_valid = 1'b1;
                                n_out       = r_pend;
                            end
                        end else begin
                            n_over = 1'b1;
                        end
                    end
                end
            end
            sse_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = sse_pkg::ST_IDLE;
                    if (r_pend_valid) begin
                        n_out            = r_pend;
                        n_out.last       = 1'b1;
                        n_out.overflow   = r_over;
                        n_out.set_status = r_over && (r_mode == sse_pkg::LIMIT_ACCURATE);
                    end else begin
                        n_out = empty_res;
                    end
                end
            end
            default: begin
                n_state = sse_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sse_pkg::ST_IDLE;
            r_tall       <= 1'b0;
            r_mode       <= sse_pkg::LIMIT_ACCURATE;
            r_issue_done <= 1'b0;
            r_chk_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_count      <= '0;
            r_over       <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_state      <= n_state;
            r_issue_done <= n_issue_done;
            r_chk_valid  <= n_chk_valid;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_count      <= n_count;
            r_over       <= n_over;
            r_idx        <= n_idx;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sse_pkg::CFG_TALL_SPRITES: r_tall <= i_cfg_data[0];
                    sse_pkg::CFG_LIMIT_MODE:   r_mode <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= n_chk_idx;
        r_line    <= n_line;
        r_pend    <= n_pend;
        r_out     <= n_out;
    end

    // A row never written reads as zero; the first byte written to it clears
    // the other three bytes at the same time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (mem_we) begin
            r_row_valid[i_head.row] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            for (int b = 0; b < 4; b++) begin
                if ((2'(b) == i_head.lane) || !r_row_valid[i_head.row]) begin
                    r_table[i_head.row][b*8 +: 8] <=
                        (2'(b) == i_head.lane) ? i_head.data : 8'h00;
                end
            end
        end
        if (rd_en) begin
            r_rd_data <= r_table[rd_row];
            r_rd_ok   <= r_row_valid[rd_row];
        end
    end

endmodule
`default_nettype wire

FILE: sv/sse_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Scanline sprite evaluator checker
// Port-level checks on the result words, bound to the top level.
// ----------------------------------------------------------------------------
module sse_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_m_tvalid,
    input wire logic                              i_m_tready,
    input wire logic [sse_pkg::OUT_DATA_W-1:0]    i_m_tdata,
    input wire logic                              i_m_tuser,
    input wire logic                              i_m_tlast
);

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> i_m_tvalid)
        else $error("result word dropped while stalled");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tuser) |-> (i_m_tlast && (i_m_tdata == '0)))
        else $error("empty result word is not a clean last word");

    a_status_needs_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tdata[39]) |-> i_m_tdata[38])
        else $error("status overflow without overflow");

    a_mid_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tlast) |-> (i_m_tuser && (i_m_tdata[39:38] == 2'b00)))
        else $error("non-last word carries an overflow report or no sprite");

endmodule

bind scanline_sprite_evaluator sse_checker u_sse_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser),
    .i_m_tlast  (m_axis_tlast)
);
`default_nettype wire
